### src/rpt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rpt_pkg
// Token kinds, error bits, character codes and the token record shared by the
// pattern tokenizer.
// ---------------------------------------------------------------------------
package rpt_pkg;

    localparam logic [3:0] K_ANY     = 4'd0;
    localparam logic [3:0] K_AEND    = 4'd1;
    localparam logic [3:0] K_ASTART  = 4'd2;
    localparam logic [3:0] K_CAPTURE = 4'd3;
    localparam logic [3:0] K_SET     = 4'd4;
    localparam logic [3:0] K_NSET    = 4'd5;
    localparam logic [3:0] K_CLOSE   = 4'd6;
    localparam logic [3:0] K_END     = 4'd7;
    localparam logic [3:0] K_INVALID = 4'd8;
    localparam logic [3:0] K_GREEDY  = 4'd9;
    localparam logic [3:0] K_GROUP   = 4'd10;
    localparam logic [3:0] K_LAZY    = 4'd11;
    localparam logic [3:0] K_LIT     = 4'd12;
    localparam logic [3:0] K_LOOK    = 4'd13;
    localparam logic [3:0] K_NLOOK   = 4'd14;
    localparam logic [3:0] K_OR      = 4'd15;

    localparam logic [5:0] E_RBRACKET = 6'h01;
    localparam logic [5:0] E_NUMBER   = 6'h02;
    localparam logic [5:0] E_REPEAT   = 6'h04;
    localparam logic [5:0] E_RBRACE   = 6'h08;
    localparam logic [5:0] E_GROUPING = 6'h10;
    localparam logic [5:0] E_CHAR     = 6'h20;

    localparam logic [15:0] CH_BANG   = 16'h0021;
    localparam logic [15:0] CH_DOLLAR = 16'h0024;
    localparam logic [15:0] CH_LPAREN = 16'h0028;
    localparam logic [15:0] CH_RPAREN = 16'h0029;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_PLUS   = 16'h002B;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_NINE   = 16'h0039;
    localparam logic [15:0] CH_COLON  = 16'h003A;
    localparam logic [15:0] CH_EQUAL  = 16'h003D;
    localparam logic [15:0] CH_QUEST  = 16'h003F;
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_CARET  = 16'h005E;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_BAR    = 16'h007C;
    localparam logic [15:0] CH_RBRACE = 16'h007D;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] spos;
        logic [15:0] epos;
        logic [15:0] rmin;
        logic [15:0] rmax;
        logic [5:0]  err;
        logic        last;
    } tok_t;

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic [15:0] spos,
                                    input logic [15:0] epos, input logic [15:0] rmin,
                                    input logic [15:0] rmax, input logic [5:0] err);
        tok_t t;
        t.kind = kind;
        t.spos = spos;
        t.epos = epos;
        t.rmin = rmin;
        t.rmax = rmax;
        t.err  = err;
        t.last = 1'b0;
        return t;
    endfunction

endpackage
`default_nettype wire

### src/regexp_pattern_tokenizer_top.sv
// a token enters the four-entry token queue when the request that completes it is accepted,
// and is on m_* once the tokens ahead of it are taken; one character is accepted per cycle
// while s_tready is high, and a character may push two tokens into the queue at once
// s_tready drops while the queue has fewer than two free entries
// reset: synchronous, active low; clears scan state, position, queue and strict mode
`default_nettype none
// ---------------------------------------------------------------------------
// regexp_pattern_tokenizer_top
// Splits a regular-expression pattern, one code unit per request, into tokens
// with one character of lookahead and {min,max} count parsing.
// ---------------------------------------------------------------------------
module regexp_pattern_tokenizer_top #(
    parameter int COUNT_INFINITY = 65535,
    parameter int POSITION_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,     // strict_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,         // [15:0] pattern code unit
    input  wire logic [0:0]  s_tuser,         // [0] end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,         // [15:0] start_pos, [31:16] end_pos,
                                              // [47:32] repeat_min, [63:48] repeat_max,
                                              // [69:64] error_flags, [71:70] zero
    output logic [3:0]       m_tuser,         // [3:0] token_kind
    output logic             m_tlast          // last_of_run
);
    import rpt_pkg::*;

    localparam int CW = $clog2(longint'(COUNT_INFINITY) + 1);
    localparam logic [CW-1:0] COUNT_MAX   = CW'(COUNT_INFINITY);
    localparam logic [CW-1:0] COUNT_TENTH = CW'(COUNT_INFINITY / 10);
    localparam int PB = POSITION_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DOLLAR   = 4'd1;
    localparam logic [3:0] S_REPQ     = 4'd2;
    localparam logic [3:0] S_PAREN    = 4'd3;
    localparam logic [3:0] S_PARENQ   = 4'd4;
    localparam logic [3:0] S_BAR      = 4'd5;
    localparam logic [3:0] S_BSLASH   = 4'd6;
    localparam logic [3:0] S_SETFIRST = 4'd7;
    localparam logic [3:0] S_SET      = 4'd8;
    localparam logic [3:0] S_SETESC   = 4'd9;
    localparam logic [3:0] S_NSET     = 4'd10;
    localparam logic [3:0] S_NSETESC  = 4'd11;
    localparam logic [3:0] S_BRACELAX = 4'd12;
    localparam logic [3:0] S_MIN      = 4'd13;
    localparam logic [3:0] S_MAXSTART = 4'd14;
    localparam logic [3:0] S_MAX      = 4'd15;

    logic          strict_reg;
    logic [3:0]    state_reg,  state_next;
    logic [PB-1:0] pos_reg,    pos_next;
    logic [PB-1:0] tstart_reg, tstart_next;
    logic [CW-1:0] clo_reg,    clo_next;
    logic [CW-1:0] chi_reg,    chi_next;
    logic          dseen_reg,  dseen_next;
    logic [5:0]    perr_reg,   perr_next;
    logic          eemit_reg,  eemit_next;

    logic [PB-1:0] np;
    logic          is_dig;
    logic [3:0]    dval;
    logic          lo_ovf, hi_ovf, h0_ovf;
    logic [CW-1:0] lo_next, hi_next;
    logic          consumed, fv, frep, sv, ds_in, neg;
    logic [3:0]    fk, sk;
    logic [PB-1:0] fe, se;
    tok_t          tok_a, tok_b, push0, push1;
    logic [1:0]    n_tok;

    // token queue
    tok_t       q_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       accept, pop;
    logic [1:0] push_n;
    tok_t       head;

    assign np     = pos_reg + 1'b1;
    assign is_dig = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign dval   = s_tdata[3:0];

    // one decimal digit of a count: v*10 + d, unless v + d reaches COUNT_INFINITY / 10
    assign lo_ovf  = ({1'b0, clo_reg} + (CW+1)'(dval)) >= {1'b0, COUNT_TENTH};
    assign lo_next = (clo_reg << 3) + (clo_reg << 1) + CW'(dval);
    assign hi_ovf  = ({1'b0, chi_reg} + (CW+1)'(dval)) >= {1'b0, COUNT_TENTH};
    assign hi_next = (chi_reg << 3) + (chi_reg << 1) + CW'(dval);
    assign h0_ovf  = CW'(dval) >= COUNT_TENTH;

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        clo_next    = clo_reg;
        chi_next    = chi_reg;
        dseen_next  = dseen_reg;
        perr_next   = perr_reg;
        eemit_next  = eemit_reg;
        consumed    = 1'b0;
        fv          = 1'b0;
        fk          = K_LIT;
        fe          = pos_reg;
        frep        = 1'b0;
        sv          = 1'b0;
        sk          = K_LIT;
        se          = np;
        ds_in       = dseen_reg;
        neg         = 1'b0;
        tok_a       = '0;
        tok_b       = '0;

        if (s_tuser[0]) begin
            if (!eemit_reg) begin
                // flush whatever token is waiting, then End
                fv = 1'b1;
                unique case (state_reg)
                    S_IDLE:   fv = 1'b0;
                    S_DOLLAR: fk = K_AEND;
                    S_REPQ: begin
                        fk   = K_GREEDY;
                        frep = 1'b1;
                    end
                    S_PAREN:  fk = strict_reg ? K_GROUP : K_LIT;
                    S_PARENQ: begin
                        if (strict_reg) perr_next = perr_next | E_GROUPING;
                        fk = K_GROUP;
                    end
                    S_BAR:    fk = K_LIT;
                    S_BSLASH: begin
                        perr_next = perr_next | E_CHAR;
                        fk = K_LIT;
                    end
                    S_SETFIRST, S_SET, S_SETESC: begin
                        perr_next = perr_next | E_RBRACKET;
                        fk = K_SET;
                    end
                    S_NSET, S_NSETESC: begin
                        perr_next = perr_next | E_RBRACKET;
                        fk = K_NSET;
                    end
                    S_BRACELAX: fk = K_LIT;
                    S_MIN: begin
                        if (!dseen_reg) perr_next = perr_next | E_NUMBER;
                        perr_next = perr_next | E_REPEAT;
                        fk = K_INVALID;
                    end
                    default: begin
                        perr_next = perr_next | E_RBRACE;
                        fk = K_INVALID;
                    end
                endcase
                if (fv) begin
                    tok_a = mk_tok(fk, 16'(tstart_reg), 16'(fe),
                                   frep ? 16'(clo_reg) : 16'd0,
                                   frep ? 16'(chi_reg) : 16'd0, perr_next);
                    perr_next = '0;
                end
                sv    = 1'b1;
                tok_b = mk_tok(K_END, 16'(pos_reg), 16'(pos_reg), 16'd0, 16'd0, perr_next);
            end
            state_next  = S_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            clo_next    = '0;
            chi_next    = '0;
            dseen_next  = 1'b0;
            perr_next   = '0;
            eemit_next  = 1'b0;
        end else if (!eemit_reg) begin
            // offer the character to the waiting token
            unique case (state_reg)
                S_DOLLAR: begin
                    fv = 1'b1;
                    fk = (s_tdata == CH_RPAREN || s_tdata == CH_SLASH) ? K_AEND : K_LIT;
                end
                S_REPQ: begin
                    fv   = 1'b1;
                    frep = 1'b1;
                    if (s_tdata == CH_QUEST) begin
                        fk       = K_LAZY;
                        fe       = np;
                        consumed = 1'b1;
                    end else begin
                        fk = K_GREEDY;
                    end
                end
                S_PAREN: begin
                    if (s_tdata == CH_QUEST) begin
                        state_next = S_PARENQ;
                        consumed   = 1'b1;
                    end else begin
                        fv = 1'b1;
                        if (strict_reg) fk = K_GROUP;
                        else fk = (s_tdata == CH_RPAREN) ? K_LIT : K_CAPTURE;
                    end
                end
                S_PARENQ: begin
                    fv = 1'b1;
                    priority if (s_tdata == CH_COLON) begin
                        fk = K_GROUP; fe = np; consumed = 1'b1;
                    end else if (s_tdata == CH_EQUAL) begin
                        fk = K_LOOK; fe = np; consumed = 1'b1;
                    end else if (s_tdata == CH_BANG) begin
                        fk = K_NLOOK; fe = np; consumed = 1'b1;
                    end else begin
                        if (strict_reg) perr_next = perr_next | E_GROUPING;
                        fk = K_GROUP;
                    end
                end
                S_BAR: begin
                    fv = 1'b1;
                    fk = (s_tdata == CH_SLASH || s_tdata == CH_RPAREN) ? K_LIT : K_OR;
                end
                S_BSLASH: begin
                    fv = 1'b1; fk = K_LIT; fe = np; consumed = 1'b1;
                end
                S_SETESC: begin
                    state_next = S_SET; consumed = 1'b1;
                end
                S_NSETESC: begin
                    state_next = S_NSET; consumed = 1'b1;
                end
                S_SETFIRST, S_SET, S_NSET: begin
                    consumed = 1'b1;
                    if (state_reg == S_SETFIRST && s_tdata == CH_CARET) begin
                        state_next = S_NSET;
                    end else begin
                        neg = (state_reg == S_NSET);
                        priority if (s_tdata == CH_RBRACK) begin
                            fv = 1'b1; fk = neg ? K_NSET : K_SET; fe = np;
                        end else if (s_tdata == CH_BSLASH) begin
                            state_next = neg ? S_NSETESC : S_SETESC;
                        end else begin
                            state_next = neg ? S_NSET : S_SET;
                        end
                    end
                end
                S_BRACELAX, S_MIN: begin
                    if (state_reg == S_BRACELAX && !is_dig) begin
                        fv = 1'b1; fk = K_LIT;
                    end else begin
                        ds_in      = (state_reg == S_BRACELAX) ? 1'b0 : dseen_reg;
                        dseen_next = ds_in;
                        state_next = S_MIN;
                        if (is_dig) begin
                            if (lo_ovf) perr_next = perr_next | E_NUMBER;
                            else clo_next = lo_next;
                            dseen_next = 1'b1;
                            consumed   = 1'b1;
                        end else begin
                            if (!ds_in) perr_next = perr_next | E_NUMBER;
                            priority if (s_tdata == CH_RBRACE) begin
                                chi_next = clo_reg; state_next = S_REPQ; consumed = 1'b1;
                            end else if (s_tdata == CH_COMMA) begin
                                state_next = S_MAXSTART; consumed = 1'b1;
                            end else begin
                                perr_next = perr_next | E_REPEAT;
                                fv = 1'b1; fk = K_INVALID;
                            end
                        end
                    end
                end
                S_MAXSTART, S_MAX: begin
                    if (is_dig) begin
                        consumed   = 1'b1;
                        state_next = S_MAX;
                        if (state_reg == S_MAXSTART) begin
                            if (h0_ovf) begin
                                perr_next = perr_next | E_NUMBER;
                                chi_next  = '0;
                            end else begin
                                chi_next = CW'(dval);
                            end
                        end else begin
                            if (hi_ovf) perr_next = perr_next | E_NUMBER;
                            else chi_next = hi_next;
                        end
                    end else begin
                        if (state_reg == S_MAXSTART) chi_next = COUNT_MAX;
                        if (s_tdata == CH_RBRACE) begin
                            state_next = S_REPQ; consumed = 1'b1;
                        end else begin
                            perr_next = perr_next | E_RBRACE;
                            fv = 1'b1; fk = K_INVALID;
                        end
                    end
                end
                default: ;
            endcase

            if (fv) begin
                tok_a = mk_tok(fk, 16'(tstart_reg), 16'(fe),
                               frep ? 16'(clo_reg) : 16'd0,
                               frep ? 16'(chi_next) : 16'd0, perr_next);
                perr_next  = '0;
                state_next = S_IDLE;
            end

            // a character not taken by the waiting token starts a new one
            if (!consumed) begin
                tstart_next = pos_reg;
                perr_next   = '0;
                sv          = 1'b1;
                unique case (s_tdata)
                    CH_DOLLAR: begin
                        if (strict_reg) sk = K_AEND;
                        else begin
                            sv = 1'b0; state_next = S_DOLLAR;
                        end
                    end
                    CH_STAR: begin
                        sv = 1'b0; clo_next = '0; chi_next = COUNT_MAX; state_next = S_REPQ;
                    end
                    CH_PLUS: begin
                        sv = 1'b0; clo_next = CW'(1); chi_next = COUNT_MAX;
                        state_next = S_REPQ;
                    end
                    CH_QUEST: begin
                        sv = 1'b0; clo_next = '0; chi_next = CW'(1); state_next = S_REPQ;
                    end
                    CH_DOT:    sk = K_ANY;
                    CH_SLASH: begin
                        sk = K_END; eemit_next = 1'b1;
                    end
                    CH_LPAREN: begin
                        sv = 1'b0; state_next = S_PAREN;
                    end
                    CH_RPAREN: sk = K_CLOSE;
                    CH_LBRACK: begin
                        sv = 1'b0; state_next = S_SETFIRST;
                    end
                    CH_LBRACE: begin
                        sv = 1'b0; clo_next = '0; chi_next = '0; dseen_next = 1'b0;
                        state_next = strict_reg ? S_MIN : S_BRACELAX;
                    end
                    CH_CARET:  sk = strict_reg ? K_ASTART : K_LIT;
                    CH_BAR: begin
                        if (strict_reg) sk = K_OR;
                        else begin
                            sv = 1'b0; state_next = S_BAR;
                        end
                    end
                    CH_BSLASH: begin
                        sv = 1'b0; state_next = S_BSLASH;
                    end
                    default:   sk = K_LIT;
                endcase
                if (sv) begin
                    tok_b      = mk_tok(sk, 16'(pos_reg), 16'(se), 16'd0, 16'd0, perr_next);
                    state_next = S_IDLE;
                end
            end
            pos_next = np;
        end
    end

    // order the tokens of this request and mark the last one
    always_comb begin
        n_tok = 2'(fv) + 2'(sv);
        push0 = fv ? tok_a : tok_b;
        push1 = tok_b;
        push0.last = (n_tok == 2'd1);
        push1.last = 1'b1;
    end

    assign s_tready = (cnt_reg <= 3'd2);
    assign accept   = s_tvalid && s_tready;
    assign push_n   = accept ? n_tok : 2'd0;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_mem[rd_ptr_reg];

    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {2'b00, head.err, head.rmax, head.rmin, head.epos, head.spos};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            strict_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            clo_reg    <= '0;
            chi_reg    <= '0;
            dseen_reg  <= 1'b0;
            perr_reg   <= '0;
            eemit_reg  <= 1'b0;
        end else if (accept) begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            clo_reg    <= clo_next;
            chi_reg    <= chi_next;
            dseen_reg  <= dseen_next;
            perr_reg   <= perr_next;
            eemit_reg  <= eemit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            cnt_reg    <= cnt_reg + 3'(push_n) - 3'(pop);
        end
    end

endmodule
`default_nettype wire

### test/regexp_pattern_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// regexp_pattern_tokenizer_top_tb
// Feeds patterns one code unit per request and checks every token against a
// behavioral tokenizer kept in step with the accepted requests, or against the
// token that a typed row gives. A short directed table comes first, then random
// patterns with noise, some of them malformed, in both syntax modes.
// ---------------------------------------------------------------------------
module regexp_pattern_tokenizer_top_tb;
    import rpt_pkg::*;

    localparam int COUNT_INF   = 65535;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1820;

    typedef enum logic [4:0] {
        SC_IDLE, SC_DOLLAR, SC_QUANT, SC_PAREN, SC_PAREN_Q, SC_BAR, SC_ESC,
        SC_SET_FIRST, SC_SET, SC_SET_ESC, SC_NSET, SC_NSET_ESC,
        SC_BRACE_LAX, SC_MIN, SC_MAX_FIRST, SC_MAX
    } scan_t;

    typedef struct packed {
        logic        strict_on;
        logic [15:0] ch;
        logic        eoi;
        logic        typed;
        tok_t        want;
    } stim_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'h0000;
    logic [0:0]  s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // tokenizer state as seen by the checker
    logic        strict   = 1'b0;
    scan_t       scan     = SC_IDLE;
    logic [15:0] pos      = 16'h0000;
    logic [15:0] tok_at   = 16'h0000;
    int          cnt_lo   = 0;
    int          cnt_hi   = 0;
    bit          seen     = 1'b0;
    logic [5:0]  pend_err = 6'h00;
    bit          end_seen = 1'b0;

    tok_t        step_toks[$];
    tok_t        tokens_due[$];
    stim_row_t   stim_rows[$];
    logic        row_strict = 1'b0;

    int          bad_tokens  = 0;
    int          n_items     = 0;
    int          phase_items = 0;
    int          stuck_cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    regexp_pattern_tokenizer_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioral tokenizer
    // ------------------------------------------------------------------
    function automatic void put_tok(input logic [3:0] k, input logic [15:0] s,
                                    input logic [15:0] e, input int mn, input int mx);
        tok_t t;
        t.kind = k;
        t.spos = s;
        t.epos = e;
        t.rmin = mn[15:0];
        t.rmax = mx[15:0];
        t.err  = pend_err;
        t.last = 1'b0;
        step_toks.insert(step_toks.size(), t);
        pend_err = 6'h00;
        scan = SC_IDLE;
    endfunction

    function automatic void put_simple(input logic [3:0] k, input logic [15:0] e);
        put_tok(k, tok_at, e, 0, 0);
    endfunction

    function automatic bit is_digit(input logic [15:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // a digit that would push the count too far is dropped and flagged
    function automatic int bump(input int v, input logic [15:0] c);
        int d;
        d = int'(c - CH_ZERO);
        if (v >= COUNT_INF / 10 - d) begin
            pend_err |= E_NUMBER;
            return v;
        end
        return v * 10 + d;
    endfunction

    function automatic bit close_max(input logic [15:0] c);
        if (c == CH_RBRACE) begin
            scan = SC_QUANT;
            return 1'b1;
        end
        pend_err |= E_RBRACE;
        put_simple(K_INVALID, pos);
        return 1'b0;
    endfunction

    // offer c to the waiting token; 1 when it was consumed
    function automatic bit offer(input logic [15:0] c);
        logic [15:0] np;
        bit          neg;
        bit          took;
        np = pos + 16'd1;
        took = 1'b0;
        case (scan)
            SC_DOLLAR: begin
                put_simple((c == CH_RPAREN || c == CH_SLASH) ? K_AEND : K_LIT, pos);
            end
            SC_QUANT: begin
                if (c == CH_QUEST) begin
                    put_tok(K_LAZY, tok_at, np, cnt_lo, cnt_hi);
                    took = 1'b1;
                end else begin
                    put_tok(K_GREEDY, tok_at, pos, cnt_lo, cnt_hi);
                end
            end
            SC_PAREN: begin
                if (c == CH_QUEST) begin
                    scan = SC_PAREN_Q;
                    took = 1'b1;
                end else if (strict) begin
                    put_simple(K_GROUP, pos);
                end else begin
                    put_simple(c == CH_RPAREN ? K_LIT : K_CAPTURE, pos);
                end
            end
            SC_PAREN_Q: begin
                took = 1'b1;
                if (c == CH_COLON) put_simple(K_GROUP, np);
                else if (c == CH_EQUAL) put_simple(K_LOOK, np);
                else if (c == CH_BANG) put_simple(K_NLOOK, np);
                else begin
                    if (strict) pend_err |= E_GROUPING;
                    put_simple(K_GROUP, pos);
                    took = 1'b0;
                end
            end
            SC_BAR: begin
                put_simple((c == CH_SLASH || c == CH_RPAREN) ? K_LIT : K_OR, pos);
            end
            SC_ESC: begin
                put_simple(K_LIT, np);
                took = 1'b1;
            end
            SC_SET_ESC: begin
                scan = SC_SET;
                took = 1'b1;
            end
            SC_NSET_ESC: begin
                scan = SC_NSET;
                took = 1'b1;
            end
            SC_SET_FIRST, SC_SET, SC_NSET: begin
                took = 1'b1;
                if (scan == SC_SET_FIRST && c == CH_CARET) begin
                    scan = SC_NSET;
                end else begin
                    if (scan == SC_SET_FIRST) scan = SC_SET;
                    neg = (scan == SC_NSET);
                    if (c == CH_RBRACK) put_simple(neg ? K_NSET : K_SET, np);
                    else if (c == CH_BSLASH) scan = neg ? SC_NSET_ESC : SC_SET_ESC;
                end
            end
            SC_BRACE_LAX, SC_MIN: begin
                if (scan == SC_BRACE_LAX && !is_digit(c)) begin
                    put_simple(K_LIT, pos);
                end else begin
                    if (scan == SC_BRACE_LAX) begin
                        scan = SC_MIN;
                        seen = 1'b0;
                    end
                    took = 1'b1;
                    if (is_digit(c)) begin
                        cnt_lo = bump(cnt_lo, c);
                        seen = 1'b1;
                    end else begin
                        if (!seen) pend_err |= E_NUMBER;
                        if (c == CH_RBRACE) begin
                            cnt_hi = cnt_lo;
                            scan = SC_QUANT;
                        end else if (c == CH_COMMA) begin
                            scan = SC_MAX_FIRST;
                        end else begin
                            pend_err |= E_REPEAT;
                            put_simple(K_INVALID, pos);
                            took = 1'b0;
                        end
                    end
                end
            end
            SC_MAX_FIRST: begin
                if (is_digit(c)) begin
                    cnt_hi = bump(0, c);
                    scan = SC_MAX;
                    took = 1'b1;
                end else begin
                    cnt_hi = COUNT_INF;
                    took = close_max(c);
                end
            end
            SC_MAX: begin
                if (is_digit(c)) begin
                    cnt_hi = bump(cnt_hi, c);
                    took = 1'b1;
                end else begin
                    took = close_max(c);
                end
            end
            default: scan = SC_IDLE;
        endcase
        return took;
    endfunction

    function automatic void begin_token(input logic [15:0] c);
        logic [15:0] np;
        np = pos + 16'd1;
        tok_at = pos;
        pend_err = 6'h00;
        case (c)
            CH_DOLLAR: begin
                if (strict) put_simple(K_AEND, np);
                else scan = SC_DOLLAR;
            end
            CH_STAR: begin
                cnt_lo = 0;
                cnt_hi = COUNT_INF;
                scan = SC_QUANT;
            end
            CH_PLUS: begin
                cnt_lo = 1;
                cnt_hi = COUNT_INF;
                scan = SC_QUANT;
            end
            CH_QUEST: begin
                cnt_lo = 0;
                cnt_hi = 1;
                scan = SC_QUANT;
            end
            CH_DOT: put_simple(K_ANY, np);
            CH_SLASH: begin
                put_simple(K_END, np);
                end_seen = 1'b1;
            end
            CH_LPAREN: scan = SC_PAREN;
            CH_RPAREN: put_simple(K_CLOSE, np);
            CH_LBRACK: scan = SC_SET_FIRST;
            CH_LBRACE: begin
                cnt_lo = 0;
                cnt_hi = 0;
                seen = 1'b0;
                scan = strict ? SC_MIN : SC_BRACE_LAX;
            end
            CH_CARET: put_simple(strict ? K_ASTART : K_LIT, np);
            CH_BAR: begin
                if (strict) put_simple(K_OR, np);
                else scan = SC_BAR;
            end
            CH_BSLASH: scan = SC_ESC;
            default: put_simple(K_LIT, np);
        endcase
    endfunction

    // close whatever token is still waiting when the pattern ends
    function automatic void flush_pending();
        case (scan)
            SC_DOLLAR: put_simple(K_AEND, pos);
            SC_QUANT: put_tok(K_GREEDY, tok_at, pos, cnt_lo, cnt_hi);
            SC_PAREN: put_simple(strict ? K_GROUP : K_LIT, pos);
            SC_PAREN_Q: begin
                if (strict) pend_err |= E_GROUPING;
                put_simple(K_GROUP, pos);
            end
            SC_BAR: put_simple(K_LIT, pos);
            SC_ESC: begin
                pend_err |= E_CHAR;
                put_simple(K_LIT, pos);
            end
            SC_SET_FIRST, SC_SET, SC_SET_ESC: begin
                pend_err |= E_RBRACKET;
                put_simple(K_SET, pos);
            end
            SC_NSET, SC_NSET_ESC: begin
                pend_err |= E_RBRACKET;
                put_simple(K_NSET, pos);
            end
            SC_BRACE_LAX: put_simple(K_LIT, pos);
            SC_MIN: begin
                if (!seen) pend_err |= E_NUMBER;
                pend_err |= E_REPEAT;
                put_simple(K_INVALID, pos);
            end
            SC_MAX_FIRST, SC_MAX: begin
                pend_err |= E_RBRACE;
                put_simple(K_INVALID, pos);
            end
            default: ;
        endcase
    endfunction

    function automatic void tokenize_char(input logic [15:0] ch, input logic eoi);
        step_toks.delete();
        if (eoi) begin
            if (!end_seen) begin
                flush_pending();
                put_tok(K_END, pos, pos, 0, 0);
            end
            scan = SC_IDLE;
            pos = 16'h0000;
            tok_at = 16'h0000;
            cnt_lo = 0;
            cnt_hi = 0;
            seen = 1'b0;
            pend_err = 6'h00;
            end_seen = 1'b0;
        end else if (!end_seen) begin
            if (scan == SC_IDLE || !offer(ch)) begin_token(ch);
            pos = pos + 16'd1;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic push_char(input logic [15:0] ch, input logic eoi, input logic typed,
                             input tok_t want);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_items++;
        phase_items++;
        tokenize_char(ch, eoi);
        if (typed) tokens_due.insert(tokens_due.size(), want);
        else foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
    endtask

    task automatic send(input logic [15:0] ch);
        push_char(ch, 1'b0, 1'b0, '0);
    endtask

    task automatic send_end();
        push_char(16'($urandom_range(0, 65535)), 1'b1, 1'b0, '0);
    endtask

    // mode changes only once every token has drained
    task automatic set_mode(input logic v);
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        strict = v;
    endtask

    function automatic logic [15:0] any_char();
        case ($urandom_range(0, 3))
            0, 1: return 16'h0061 + 16'($urandom_range(0, 25));
            2: return 16'($urandom_range(0, 65535));
            default: return CH_ZERO + 16'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send(CH_ZERO + 16'($urandom_range(0, 9)));
    endtask

    task automatic send_fragment();
        int n;
        case ($urandom_range(0, 39))
            0, 1, 2, 3, 4, 5: send(any_char());
            6, 7: send(CH_DOT);
            8, 9, 10, 11: begin
                case ($urandom_range(0, 2))
                    0: send(CH_STAR);
                    1: send(CH_PLUS);
                    default: send(CH_QUEST);
                endcase
                if ($urandom_range(0, 2) == 0) send(CH_QUEST);
            end
            12, 13, 14, 15, 16: begin
                send(CH_LBRACE);
                send_digits($urandom_range(0, 6));
                if ($urandom_range(0, 3) != 0) begin
                    send(CH_COMMA);
                    send_digits($urandom_range(0, 6));
                end
                if ($urandom_range(0, 5) != 0) send(CH_RBRACE);
                if ($urandom_range(0, 2) == 0) send(CH_QUEST);
            end
            17, 18, 19, 20: begin
                send(CH_LPAREN);
                case ($urandom_range(0, 4))
                    0: ;
                    1: begin send(CH_QUEST); send(CH_COLON); end
                    2: begin send(CH_QUEST); send(CH_EQUAL); end
                    3: begin send(CH_QUEST); send(CH_BANG); end
                    default: begin send(CH_QUEST); send(any_char()); end
                endcase
            end
            21, 22: send(CH_RPAREN);
            23, 24, 25, 26: begin
                send(CH_LBRACK);
                if ($urandom_range(0, 1) == 0) send(CH_CARET);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) send(CH_BSLASH);
                    send(any_char());
                end
                if ($urandom_range(0, 5) != 0) send(CH_RBRACK);
            end
            27, 28: begin
                send(CH_BSLASH);
                send(any_char());
            end
            29, 30: send(CH_DOLLAR);
            31, 32: send(CH_CARET);
            33, 34, 35: send(CH_BAR);
            36, 37: send(16'($urandom_range(0, 65535)));
            default: send(CH_SLASH);
        endcase
    endtask

    task automatic send_pattern();
        int nfrag;
        nfrag = $urandom_range(1, 10);
        for (int k = 0; k < nfrag; k++) send_fragment();
        send_end();
    endtask

    function automatic void add_row(input logic [15:0] ch, input logic eoi);
        stim_row_t r;
        r = '0;
        r.strict_on = row_strict;
        r.ch = ch;
        r.eoi = eoi;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void add_typed(input logic [15:0] ch, input logic [3:0] k,
                                      input logic [15:0] s, input logic [15:0] e,
                                      input logic [15:0] mn, input logic [15:0] mx);
        stim_row_t r;
        r = '0;
        r.strict_on = row_strict;
        r.ch = ch;
        r.typed = 1'b1;
        r.want.kind = k;
        r.want.spos = s;
        r.want.epos = e;
        r.want.rmin = mn;
        r.want.rmax = mx;
        r.want.last = 1'b1;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 36);
            end
        end
    end

    function automatic string fmt_tok(input tok_t t);
        return $sformatf("kind=%0d start=%0d end=%0d min=%0d max=%0d err=%h last=%0d",
                         t.kind, t.spos, t.epos, t.rmin, t.rmax, t.err, t.last);
    endfunction

    always @(posedge aclk) begin
        tok_t got;
        tok_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.spos = m_tdata[15:0];
            got.epos = m_tdata[31:16];
            got.rmin = m_tdata[47:32];
            got.rmax = m_tdata[63:48];
            got.err  = m_tdata[69:64];
            got.last = m_tlast;
            if (tokens_due.size() == 0) begin
                bad_tokens++;
                $display("%0t: unexpected token: expected none, actual %s",
                         $time, fmt_tok(got));
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    bad_tokens++;
                    $display("%0t: token mismatch: expected %s, actual %s",
                             $time, fmt_tok(want), fmt_tok(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;

        // lenient mode
        row_strict = 1'b0;
        add_typed(CH_DOT, K_ANY, 16'd0, 16'd1, 16'd0, 16'd0);
        add_row(CH_STAR, 1'b0);
        add_typed(CH_QUEST, K_LAZY, 16'd1, 16'd3, 16'd0, 16'hFFFF);
        add_row(CH_BAR, 1'b0);              // bar before a letter: alternation
        add_row(16'h0078, 1'b0);
        add_row(CH_BAR, 1'b0);              // bar at the end: literal
        add_row(16'h0000, 1'b1);
        add_row(CH_LPAREN, 1'b0);
        add_row(CH_QUEST, 1'b0);
        add_row(16'h0000, 1'b1);
        add_row(CH_BSLASH, 1'b0);           // dangling escape
        add_row(16'h0000, 1'b1);
        add_row(CH_LBRACK, 1'b0);           // unterminated set
        add_row(16'h0000, 1'b1);
        add_typed(16'hFFFF, K_LIT, 16'd0, 16'd1, 16'd0, 16'd0);
        add_typed(CH_SLASH, K_END, 16'd1, 16'd2, 16'd0, 16'd0);
        add_row(16'h8000, 1'b0);            // ignored after the end marker
        add_row(16'h0000, 1'b1);
        // strict mode
        row_strict = 1'b1;
        add_row(CH_LPAREN, 1'b0);
        add_row(CH_QUEST, 1'b0);
        add_row(16'h0000, 1'b1);
        add_typed(CH_DOLLAR, K_AEND, 16'd0, 16'd1, 16'd0, 16'd0);
        add_row(CH_LBRACE, 1'b0);           // braces with no digit
        add_row(CH_RBRACE, 1'b0);
        add_row(16'h0000, 1'b1);
        add_row(CH_LBRACE, 1'b0);           // minimum never closed
        add_row(CH_ZERO + 16'd5, 1'b0);
        add_row(16'h0000, 1'b1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_mode(1'b0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].strict_on != strict) set_mode(stim_rows[i].strict_on);
            push_char(stim_rows[i].ch, stim_rows[i].eoi, stim_rows[i].typed,
                      stim_rows[i].want);
        end

        n_items = 0;
        phase = 0;
        while (n_items < RANDOM_ITEMS) begin
            set_mode(phase[0] ^ ($urandom_range(0, 3) == 0));
            phase_items = 0;
            no_idle = (phase == 3);
            if (phase == 2) hold_req = 1'b1;
            while (phase_items < 250 && n_items < RANDOM_ITEMS) send_pattern();
            phase++;
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (bad_tokens == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
src/rpt_pkg.sv
src/regexp_pattern_tokenizer_top.sv
test/regexp_pattern_tokenizer_top_tb.sv
